### design/bbg_pkg.sv
// Shared types and constants for the battery bar-graph LED driver.
package bbg_pkg;

  localparam int PIX_W      = 5;
  localparam int CNT_W      = 6;
  localparam int VOLT_W     = 14;
  localparam int BRIGHT_W   = 8;
  localparam int ERPM_W     = 21;
  localparam int TURNOFF_W  = 20;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int PROD_W     = VOLT_W + CNT_W;
  localparam int DIVIDEND_W = 21;
  localparam int DIVISOR_W  = VOLT_W;
  localparam int DIV_CNT_W  = 5;
  localparam int REM_W      = 7;
  localparam int GPROD_W    = REM_W + BRIGHT_W;
  localparam int RECIP_W    = 13;
  localparam int RECIP_SH   = 19;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOLTAGE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLTAGE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TURNOFF_ERPM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSED     = 3'd5;

  localparam logic [BRIGHT_W-1:0] PURPLE_LEVEL = 8'd153;
  localparam logic [6:0]          PERCENT      = 7'd100;
  // floor(x/100) == (x*5243)>>19 for every x < 2^15
  localparam logic [RECIP_W-1:0]  RECIP_100    = 13'd5243;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_HALF_A = 2'd1,
    MODE_HALF_B = 2'd2,
    MODE_FULL   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    K_DARK    = 2'd0,
    K_PATTERN = 2'd1,
    K_RED     = 2'd2,
    K_GAUGE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV1_GO,
    S_DIV1,
    S_DIV2_GO,
    S_DIV2,
    S_SCALE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } div_res_t;

endpackage

### design/bbg_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module bbg_div
  import bbg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output div_res_t              res
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIVIDEND_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      rem_nxt = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

### design/battery_bar_graph_led_driver.sv
// Battery bar-graph LED driver: config registers, sequencer and pixel output.
// Gauge updates make two passes through the shared divider before the pixel run;
// dark, pattern and all-red updates go straight to the pixel run.
// Throughput: one update transaction at a time; in_ready is high only when idle.
// Output is registered, so a pixel waits on out_ready without losing data.
// Synchronous active-low reset restores the config defaults and clears mode and hold time.
module battery_bar_graph_led_driver
  import bbg_pkg::*;
#(
  parameter int MAX_PIXELS = 32,
  parameter int HOLD_MS    = 2000
)
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [VOLT_W-1:0]       in_voltage_cv,
  input  logic [1:0]              in_switch_state,
  input  logic                    in_adc1_above_adc2,
  input  logic signed [ERPM_W-1:0] in_erpm,
  input  logic [TIME_W-1:0]       in_now_ms,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PIX_W-1:0]        out_pixel_index,
  output logic [BRIGHT_W-1:0]     out_red,
  output logic [BRIGHT_W-1:0]     out_green,
  output logic [BRIGHT_W-1:0]     out_blue,
  output logic                    out_last_pixel
);

  localparam int LIMIT = (MAX_PIXELS < 32) ? MAX_PIXELS : 32;

  logic [CNT_W-1:0]     pixel_count_r;
  logic [VOLT_W-1:0]    min_v_r;
  logic [VOLT_W-1:0]    max_v_r;
  logic [BRIGHT_W-1:0]  bright_r;
  logic [TURNOFF_W-1:0] turnoff_r;
  logic                 reversed_r;

  mode_t                last_mode_r, last_mode_nxt;
  logic [TIME_W-1:0]    last_change_r, last_change_nxt;

  state_t               state_r, state_nxt;
  kind_t                kind_r, kind_nxt;
  mode_t                mode_r, mode_nxt;
  logic [CNT_W-1:0]     n_r;
  logic [VOLT_W-1:0]    val_r;
  logic [VOLT_W-1:0]    rng_r;
  logic [PROD_W-1:0]    prod_r;
  logic [PROD_W-1:0]    whole_r;
  logic [DIVIDEND_W-1:0] scaled_r;
  logic [GPROD_W-1:0]   gprod_r;
  logic [BRIGHT_W-1:0]  g_r;
  logic [PIX_W-1:0]     p_r;

  logic                 out_valid_r;
  logic [PIX_W-1:0]     out_idx_r;
  logic [BRIGHT_W-1:0]  out_red_r, out_green_r, out_blue_r;
  logic                 out_last_r;

  logic                 acc, emit_fire, last_pos;
  logic                 div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  div_res_t             div_res;
  mode_t                mode_in;
  logic [CNT_W-1:0]     n_in;
  logic [ERPM_W-1:0]    mag;
  logic                 too_fast, held, no_range;
  logic [TIME_W-1:0]    elapsed;
  logic [CNT_W-1:0]     half;
  logic                 lit;
  logic [PIX_W-1:0]     phys;
  logic [BRIGHT_W-1:0]  pr, pg, pb;
  logic [GPROD_W+RECIP_W-1:0] gscale;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign last_pos  = ({1'b0, p_r} == n_r - 1'b1);

  always_comb begin
    unique case (in_switch_state)
      2'd1:    mode_in = in_adc1_above_adc2 ? MODE_HALF_A : MODE_HALF_B;
      2'd2:    mode_in = MODE_FULL;
      default: mode_in = MODE_NONE;
    endcase
  end

  assign n_in     = (pixel_count_r > CNT_W'(LIMIT)) ? CNT_W'(LIMIT) : pixel_count_r;
  assign mag      = in_erpm[ERPM_W-1] ? ERPM_W'(-in_erpm) : in_erpm;
  assign too_fast = mag > {1'b0, turnoff_r};
  assign elapsed  = in_now_ms - last_change_r;
  assign held     = elapsed < TIME_W'(HOLD_MS);
  assign no_range = (in_voltage_cv < min_v_r) || (max_v_r <= min_v_r);

  bbg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (rng_r),
    .res      (div_res)
  );

  assign div_dividend = (state_r == S_DIV1_GO) ? DIVIDEND_W'(prod_r) : scaled_r;

  always_comb begin
    state_nxt       = state_r;
    kind_nxt        = kind_r;
    mode_nxt        = mode_r;
    last_mode_nxt   = last_mode_r;
    last_change_nxt = last_change_r;
    div_start       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (too_fast) begin
            kind_nxt  = K_DARK;
            state_nxt = (n_in == '0) ? S_IDLE : S_EMIT;
          end else if (mode_in != last_mode_r) begin
            kind_nxt        = K_PATTERN;
            mode_nxt        = mode_in;
            last_mode_nxt   = mode_in;
            last_change_nxt = in_now_ms;
            state_nxt       = (n_in == '0) ? S_IDLE : S_EMIT;
          end else if (held) begin
            state_nxt = S_IDLE;
          end else if (no_range) begin
            kind_nxt  = K_RED;
            state_nxt = (n_in == '0) ? S_IDLE : S_EMIT;
          end else begin
            kind_nxt  = K_GAUGE;
            state_nxt = (n_in == '0) ? S_IDLE : S_MUL;
          end
        end
      end
      S_MUL:     state_nxt = S_DIV1_GO;
      S_DIV1_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV1;
      end
      S_DIV1:    if (div_res.done) state_nxt = S_DIV2_GO;
      S_DIV2_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV2;
      end
      S_DIV2:    if (div_res.done) state_nxt = S_SCALE;
      S_SCALE:   state_nxt = S_EMIT;
      S_EMIT:    if (emit_fire && last_pos) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      kind_r        <= K_DARK;
      mode_r        <= MODE_NONE;
      last_mode_r   <= MODE_NONE;
      last_change_r <= '0;
      pixel_count_r <= 6'd8;
      min_v_r       <= 14'd3000;
      max_v_r       <= 14'd4200;
      bright_r      <= 8'd255;
      turnoff_r     <= 20'd3000;
      reversed_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      kind_r        <= kind_nxt;
      mode_r        <= mode_nxt;
      last_mode_r   <= last_mode_nxt;
      last_change_r <= last_change_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PIXEL_COUNT:  pixel_count_r <= cfg_data[CNT_W-1:0];
          CFG_MIN_VOLTAGE:  min_v_r       <= cfg_data[VOLT_W-1:0];
          CFG_MAX_VOLTAGE:  max_v_r       <= cfg_data[VOLT_W-1:0];
          CFG_BRIGHTNESS:   bright_r      <= cfg_data[BRIGHT_W-1:0];
          CFG_TURNOFF_ERPM: turnoff_r     <= cfg_data[TURNOFF_W-1:0];
          CFG_REVERSED:     reversed_r    <= cfg_data[0];
          default:          ;
        endcase
      end
    end
  end

  assign gscale = gprod_r * RECIP_100;

  // gauge datapath: q = value*n*100/range split as whole = a/range, rem = (a%range)*100/range
  always_ff @(posedge clk) begin
    if (acc) begin
      n_r   <= n_in;
      val_r <= in_voltage_cv - min_v_r;
      rng_r <= max_v_r - min_v_r;
    end
    if (state_r == S_MUL) prod_r <= val_r * n_r;
    if (state_r == S_DIV1 && div_res.done) begin
      whole_r  <= div_res.quotient[PROD_W-1:0];
      scaled_r <= DIVIDEND_W'(div_res.remainder) * DIVIDEND_W'(PERCENT);
    end
    if (state_r == S_DIV2 && div_res.done) begin
      gprod_r <= div_res.quotient[REM_W-1:0] * bright_r;
    end
    if (state_r == S_SCALE) g_r <= gscale[RECIP_SH +: BRIGHT_W];
    if (acc) begin
      p_r <= '0;
    end else if (emit_fire) begin
      p_r <= p_r + 1'b1;
    end
  end

  assign half = n_r >> 1;
  assign phys = reversed_r ? PIX_W'(n_r - 1'b1 - {1'b0, p_r}) : p_r;

  always_comb begin
    unique case (mode_r)
      MODE_HALF_A: lit = n_r[0] ? ({1'b0, p_r} > half) : ({1'b0, p_r} >= half);
      MODE_HALF_B: lit = ({1'b0, p_r} < half);
      default:     lit = 1'b1;
    endcase
  end

  always_comb begin
    pr = '0;
    pg = '0;
    pb = '0;
    unique case (kind_r)
      K_PATTERN: begin
        if (mode_r == MODE_FULL) begin
          pb = PURPLE_LEVEL;
        end else if (lit) begin
          pr = PURPLE_LEVEL;
          pb = PURPLE_LEVEL;
        end
      end
      K_RED: pr = bright_r;
      K_GAUGE: begin
        if (PROD_W'(p_r) < whole_r) begin
          pg = bright_r;
        end else if (PROD_W'(p_r) == whole_r) begin
          pr = bright_r - g_r;
          pg = g_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (emit_fire) begin
      out_idx_r   <= phys;
      out_red_r   <= pr;
      out_green_r <= pg;
      out_blue_r  <= pb;
      out_last_r  <= last_pos;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_idx_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_last_pixel  = out_last_r;

endmodule

### design/bbg_checker.sv
// Port-level checker for the battery bar-graph LED driver, bound to the top level.
module bbg_checker
  import bbg_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [PIX_W-1:0]         out_pixel_index,
  input logic [BRIGHT_W-1:0]      out_red,
  input logic [BRIGHT_W-1:0]      out_green,
  input logic [BRIGHT_W-1:0]      out_blue,
  input logic                     out_last_pixel
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_index) && $stable(out_red)
      && $stable(out_green) && $stable(out_blue) && $stable(out_last_pixel))
    else $error("result changed while stalled");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_pixel |=> out_valid)
    else $error("gap inside a pixel run");

  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel |-> !in_ready)
    else $error("new update accepted mid-run");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind battery_bar_graph_led_driver bbg_checker u_bbg_checker (.*);

### tb/tb.sv
// Testbench for battery_bar_graph_led_driver: random and directed updates checked per pixel.
`timescale 1ns / 100ps

module tb
  import bbg_pkg::*;
;

  localparam int MAX_PIXELS    = 32;
  localparam int HOLD_MS       = 2000;
  localparam int ERPM_MAX      = 1048575;
  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT   = 500000;

  localparam logic [1:0] SW_NONE     = 2'd0;
  localparam logic [1:0] SW_HALF     = 2'd1;
  localparam logic [1:0] SW_FULL     = 2'd2;
  localparam logic [1:0] SW_RESERVED = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0]    phys;
    logic [BRIGHT_W-1:0] red;
    logic [BRIGHT_W-1:0] green;
    logic [BRIGHT_W-1:0] blue;
    logic                last;
  } pixel_t;

  class led_bar_predictor;
    logic [CNT_W-1:0]     pix_cnt;
    logic [VOLT_W-1:0]    min_cv;
    logic [VOLT_W-1:0]    max_cv;
    logic [BRIGHT_W-1:0]  bright;
    logic [TURNOFF_W-1:0] turnoff;
    logic                 rev;
    mode_t                last_mode;
    logic [TIME_W-1:0]    last_change_ms;
    pixel_t               pixels_due[$];

    function new();
      pix_cnt        = 6'd8;
      min_cv         = 14'd3000;
      max_cv         = 14'd4200;
      bright         = 8'd255;
      turnoff        = 20'd3000;
      rev            = 1'b0;
      last_mode      = MODE_NONE;
      last_change_ms = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PIXEL_COUNT:  pix_cnt = data[CNT_W-1:0];
        CFG_MIN_VOLTAGE:  min_cv  = data[VOLT_W-1:0];
        CFG_MAX_VOLTAGE:  max_cv  = data[VOLT_W-1:0];
        CFG_BRIGHTNESS:   bright  = data[BRIGHT_W-1:0];
        CFG_TURNOFF_ERPM: turnoff = data[TURNOFF_W-1:0];
        CFG_REVERSED:     rev     = data[0];
        default: ;
      endcase
    endfunction

    function mode_t mode_of(logic [1:0] sw, logic adc);
      if (sw == SW_HALF) return adc ? MODE_HALF_A : MODE_HALF_B;
      if (sw == SW_FULL) return MODE_FULL;
      return MODE_NONE;
    endfunction

    function void push_pixel(int unsigned pos, int unsigned n,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_t px;
      px.phys  = rev ? PIX_W'(n - 1 - pos) : PIX_W'(pos);
      px.red   = r;
      px.green = g;
      px.blue  = b;
      px.last  = (pos + 1 == n);
      pixels_due.push_back(px);
    endfunction

    function void accept_update(logic [VOLT_W-1:0] volt, logic [1:0] sw, logic adc,
                                logic signed [ERPM_W-1:0] erpm, logic [TIME_W-1:0] now);
      int unsigned       n;
      int unsigned       half;
      int unsigned       rem;
      int unsigned       g;
      int                speed;
      mode_t             m;
      logic [TIME_W-1:0] elapsed;
      longint            value;
      longint            span;
      longint            q;
      longint            whole;
      logic              lit;
      n = (pix_cnt > MAX_PIXELS) ? MAX_PIXELS : pix_cnt;
      if (n > 32) n = 32;
      m = mode_of(sw, adc);
      speed = erpm;
      if (speed < 0) speed = -speed;
      // fast motor: dark bar, state untouched
      if (speed > int'(turnoff)) begin
        for (int p = 0; p < n; p++) push_pixel(p, n, 0, 0, 0);
        return;
      end
      if (m != last_mode) begin
        half = n / 2;
        for (int p = 0; p < n; p++) begin
          case (m)
            MODE_NONE:   lit = 1'b1;
            MODE_HALF_A: lit = (n % 2) ? (p > half) : (p >= half);
            MODE_HALF_B: lit = (p < half);
            default:     lit = 1'b0;
          endcase
          if (m == MODE_FULL) push_pixel(p, n, 0, 0, PURPLE_LEVEL);
          else if (lit) push_pixel(p, n, PURPLE_LEVEL, 0, PURPLE_LEVEL);
          else push_pixel(p, n, 0, 0, 0);
        end
        last_mode      = m;
        last_change_ms = now;
        return;
      end
      elapsed = now - last_change_ms;
      if (elapsed < HOLD_MS) return;
      value = longint'(volt) - longint'(min_cv);
      span  = longint'(max_cv) - longint'(min_cv);
      if (value < 0 || span <= 0) begin
        for (int p = 0; p < n; p++) push_pixel(p, n, bright, 0, 0);
        return;
      end
      q     = value * n * 100 / span;
      whole = q / 100;
      rem   = 32'(q % 100);
      g     = rem * bright / 100;
      for (int p = 0; p < n; p++) begin
        if (p < whole) push_pixel(p, n, 0, bright, 0);
        else if (p == whole) push_pixel(p, n, 8'(bright - g), 8'(g), 0);
        else push_pixel(p, n, 0, 0, 0);
      end
    endfunction

    function string check_pixel(pixel_t got);
      pixel_t want;
      string  bad;
      if (pixels_due.size() == 0)
        return $sformatf("unexpected pixel idx=%0d rgb=%0d,%0d,%0d last=%0d",
                         got.phys, got.red, got.green, got.blue, got.last);
      want = pixels_due.pop_front();
      bad  = "";
      if (got.phys !== want.phys) bad = {bad, " pixel_index"};
      if (got.red !== want.red) bad = {bad, " red"};
      if (got.green !== want.green) bad = {bad, " green"};
      if (got.blue !== want.blue) bad = {bad, " blue"};
      if (got.last !== want.last) bad = {bad, " last_pixel"};
      if (bad == "") return "";
      return $sformatf("bad%s: got idx=%0d rgb=%0d,%0d,%0d last=%0d, exp idx=%0d rgb=%0d,%0d,%0d last=%0d",
                       bad, got.phys, got.red, got.green, got.blue, got.last,
                       want.phys, want.red, want.green, want.blue, want.last);
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [VOLT_W-1:0]        in_voltage_cv = '0;
  logic [1:0]               in_switch_state = '0;
  logic                     in_adc1_above_adc2 = 1'b0;
  logic signed [ERPM_W-1:0] in_erpm = '0;
  logic [TIME_W-1:0]        in_now_ms = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [PIX_W-1:0]         out_pixel_index;
  logic [BRIGHT_W-1:0]      out_red;
  logic [BRIGHT_W-1:0]      out_green;
  logic [BRIGHT_W-1:0]      out_blue;
  logic                     out_last_pixel;

  led_bar_predictor  bar = new();
  int                mismatches = 0;
  int                cycles = 0;
  int                in_idle_pct = 0;
  int                out_stall_pct = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  battery_bar_graph_led_driver #(
    .MAX_PIXELS(MAX_PIXELS),
    .HOLD_MS   (HOLD_MS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_voltage_cv     (in_voltage_cv),
    .in_switch_state   (in_switch_state),
    .in_adc1_above_adc2(in_adc1_above_adc2),
    .in_erpm           (in_erpm),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_index   (out_pixel_index),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_last_pixel    (out_last_pixel)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("battery_bar_graph_led_driver verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0d: %s", cycles, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : pixel_monitor
    pixel_t got;
    string  msg;
    if (rst_n && out_valid && out_ready) begin
      got.phys  = out_pixel_index;
      got.red   = out_red;
      got.green = out_green;
      got.blue  = out_blue;
      got.last  = out_last_pixel;
      msg = bar.check_pixel(got);
      if (msg != "") report_mismatch(msg);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    bar.write_reg(idx, data);
  endtask

  task automatic configure(int n, int min_v, int max_v, int mb, int lim, int rev);
    write_reg(CFG_PIXEL_COUNT, CFG_DATA_W'(n));
    write_reg(CFG_MIN_VOLTAGE, CFG_DATA_W'(min_v));
    write_reg(CFG_MAX_VOLTAGE, CFG_DATA_W'(max_v));
    write_reg(CFG_BRIGHTNESS, CFG_DATA_W'(mb));
    write_reg(CFG_TURNOFF_ERPM, CFG_DATA_W'(lim));
    write_reg(CFG_REVERSED, CFG_DATA_W'(rev));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_update(logic [VOLT_W-1:0] volt, logic [1:0] sw, logic adc,
                             logic signed [ERPM_W-1:0] erpm, logic [TIME_W-1:0] now);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_voltage_cv      <= volt;
    in_switch_state    <= sw;
    in_adc1_above_adc2 <= adc;
    in_erpm            <= erpm;
    in_now_ms          <= now;
    do @(posedge clk); while (!in_ready);
    bar.accept_update(volt, sw, adc, erpm, now);
  endtask

  task automatic send_random_update();
    logic [VOLT_W-1:0] volt;
    logic [1:0]        sw;
    logic              adc;
    int                mag;
    int                lim;
    int                pick;
    pick = $urandom_range(99);
    if (pick < 60 && bar.max_cv > bar.min_cv)
      volt = VOLT_W'($urandom_range(bar.max_cv, bar.min_cv));
    else if (pick < 68) volt = '0;
    else if (pick < 76) volt = '1;
    else volt = VOLT_W'($urandom_range(16383));
    adc = 1'($urandom_range(1));
    // mostly hold the mode so the gauge gets drawn
    if ($urandom_range(99) < 20) sw = 2'($urandom_range(3));
    else begin
      case (bar.last_mode)
        MODE_NONE:   sw = $urandom_range(1) ? SW_RESERVED : SW_NONE;
        MODE_HALF_A: begin
          sw  = SW_HALF;
          adc = 1'b1;
        end
        MODE_HALF_B: begin
          sw  = SW_HALF;
          adc = 1'b0;
        end
        default:     sw = SW_FULL;
      endcase
    end
    lim = int'(bar.turnoff);
    if ($urandom_range(9) == 0 && lim < ERPM_MAX) mag = $urandom_range(ERPM_MAX, lim + 1);
    else mag = $urandom_range(lim);
    if ($urandom_range(1)) mag = -mag;
    pick = $urandom_range(99);
    if (pick < 65) clock_ms = clock_ms + $urandom_range(60000, HOLD_MS);
    else if (pick < 85) clock_ms = clock_ms + $urandom_range(HOLD_MS - 1);
    else if (pick < 93) clock_ms = $urandom;
    else clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
    send_update(volt, sw, adc, ERPM_W'(mag), clock_ms);
  endtask

  task automatic wait_drained();
    while (bar.pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int items);
    repeat (items) send_random_update();
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // reset config: 8 pixels, 3000..4200 cV, brightness 255, limit 3000 erpm
  task automatic run_directed();
    send_update(3600, SW_NONE, 0, 0, 100);               // hold still running
    send_update(3600, SW_RESERVED, 1, 0, 5000);          // reserved acts as none
    send_update(2999, SW_NONE, 0, 3000, 5100);           // below min, speed at limit
    send_update(16383, SW_NONE, 1, -3000, 5150);         // above max
    send_update(3000, SW_NONE, 0, 0, 5200);              // exactly min
    send_update(3456, SW_NONE, 0, 0, 5250);              // partial pixel blend
    send_update(0, SW_NONE, 0, 3001, 5300);              // over speed
    send_update(16383, SW_FULL, 1, -ERPM_MAX, 5400);     // over speed, mode not taken
    send_update(3600, SW_HALF, 1, 0, 5500);              // half, first pad
    send_update(3600, SW_HALF, 1, 0, 7499);              // hold one ms short
    send_update(3600, SW_HALF, 1, 0, 7500);              // hold just over
    send_update(4200, SW_HALF, 0, ERPM_MAX, 7600);
    send_update(4200, SW_HALF, 0, 0, 7700);              // half, second pad
    send_update(4200, SW_FULL, 0, 0, 7800);
    send_update(4200, SW_RESERVED, 0, 0, 7900);
    send_update(3900, SW_FULL, 1, 0, 32'hFFFF_FF00);
    send_update(3900, SW_FULL, 0, 0, 32'h0000_0500);     // time wrap, hold running
    send_update(3900, SW_FULL, 1, 0, 32'h0000_07D0);     // time wrap, hold over
    clock_ms = 32'h0000_07D0;
  endtask

  initial begin
    int lo;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_phase(12);
    for (int ph = 1; ph <= 8; ph++) begin
      case (ph % 4)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct   = 51;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 51;
        end
        default: begin
          in_idle_pct   = 33;
          out_stall_pct = 33;
        end
      endcase
      case (ph)
        1: configure(1, 0, 16383, 0, 0, 1);
        2: configure(32, 0, 1, 255, ERPM_MAX, 1);
        3: configure(63, 16383, 16383, 200, ERPM_MAX, 0);
        4: configure(0, 3000, 4200, 255, 3000, 0);
        5: configure(7, 3300, 4200, 128, 50000, 1);
        default: begin
          lo = $urandom_range(5000, 1000);
          configure($urandom_range(40, 1), lo,
                    ($urandom_range(99) < 15) ? $urandom_range(16383)
                                              : lo + $urandom_range(3000, 1),
                    $urandom_range(255), $urandom_range(200000), $urandom_range(1));
        end
      endcase
      run_phase((ph == 4) ? 10 : 26);
    end
    if (mismatches == 0) $display("battery_bar_graph_led_driver verification clean");
    else $display("battery_bar_graph_led_driver verification failed");
    $finish;
  end

endmodule

### battery_bar_graph_led_driver.f
design/bbg_pkg.sv
design/bbg_div.sv
design/battery_bar_graph_led_driver.sv
design/bbg_checker.sv
tb/tb.sv
